FILE: design/mbrot_pkg.sv
// Shared types, constants and register map of the escape-time pixel engine.
package mbrot_pkg;

  // Fixed-point fraction bits of every real value (origins signed Q4.28, steps unsigned Q3.28)
  localparam int FRAC_BITS = 28;

  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_ITER_BITS  = 16;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [2:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [2:0] REG_REAL_STEP   = 3'd2;
  localparam logic [2:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [2:0] REG_ITER_CAP    = 3'd4;

  localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd536870912;
  localparam logic signed [31:0] RST_IMAG_ORIGIN = -32'sd402653184;
  localparam logic [30:0]        RST_REAL_STEP   = 31'd1006633;
  localparam logic [30:0]        RST_IMAG_STEP   = 31'd1342177;
  localparam logic [15:0]        RST_ITER_CAP    = 16'd1000;

  typedef struct packed {
    logic signed [31:0] real_origin;
    logic signed [31:0] imag_origin;
    logic [30:0]        real_step;
    logic [30:0]        imag_step;
    logic [15:0]        iter_cap;
  } cfg_t;

  typedef struct packed {
    logic load;   // capture the pixel coordinate
    logic scale;  // coordinate times step
    logic orig;   // add origin, clear z
    logic iter;   // escape checks and z update
    logic sqr;    // squares and cross product of z
    logic emit;   // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic done;   // iteration loop finished this cycle
  } dp_sts_t;

endpackage

FILE: design/mbrot_cfg.sv
// APB register bank holding origin, step and iteration limit.
module mbrot_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbrot_pkg::PADDR_W-1:0]     paddr,
  input  logic [mbrot_pkg::PDATA_W-1:0]     pwdata,
  output logic [mbrot_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  output mbrot_pkg::cfg_t                   cfg_o
);
  import mbrot_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_origin <= RST_REAL_ORIGIN;
      cfg_q.imag_origin <= RST_IMAG_ORIGIN;
      cfg_q.real_step   <= RST_REAL_STEP;
      cfg_q.imag_step   <= RST_IMAG_STEP;
      cfg_q.iter_cap    <= RST_ITER_CAP;
    end else if (wr) begin
      unique case (idx)
        REG_REAL_ORIGIN: cfg_q.real_origin <= $signed(pwdata[31:0]);
        REG_IMAG_ORIGIN: cfg_q.imag_origin <= $signed(pwdata[31:0]);
        REG_REAL_STEP:   cfg_q.real_step   <= pwdata[30:0];
        REG_IMAG_STEP:   cfg_q.imag_step   <= pwdata[30:0];
        REG_ITER_CAP:    cfg_q.iter_cap    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REAL_ORIGIN: prdata = cfg_q.real_origin;
      REG_IMAG_ORIGIN: prdata = cfg_q.imag_origin;
      REG_REAL_STEP:   prdata = {1'b0, cfg_q.real_step};
      REG_IMAG_STEP:   prdata = {1'b0, cfg_q.imag_step};
      REG_ITER_CAP:    prdata = {16'd0, cfg_q.iter_cap};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/mbrot_dp.sv
// Datapath: point mapping, z update, squaring and result register.
module mbrot_dp #(
  parameter int COORD_BITS = mbrot_pkg::DEF_COORD_BITS,
  parameter int ITER_BITS  = mbrot_pkg::DEF_ITER_BITS
) (
  input  logic                  clk_i,
  input  mbrot_pkg::cfg_t       cfg_i,
  input  mbrot_pkg::dp_cmd_t    cmd_i,
  output mbrot_pkg::dp_sts_t    sts_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic [ITER_BITS-1:0]  iterations_o,
  output logic                  escaped_o,
  output logic [23:0]           color_o
);
  import mbrot_pkg::*;

  localparam int PW = COORD_BITS + 31;          // coordinate times step
  localparam int CW = PW + 2;                   // signed point c
  localparam int MW = FRAC_BITS + 1;            // |z| while still bounded
  localparam int SW = FRAC_BITS + 2;            // truncated square / product
  localparam int ZW = ((CW > SW + 2) ? CW : SW + 2) + 1;
  localparam logic signed [ZW-1:0] TWO_M1 = (ZW'(1) <<< (FRAC_BITS + 1)) - ZW'(1);
  localparam logic signed [ZW-1:0] NEG_TWO_M1 = -TWO_M1;

  logic [COORD_BITS-1:0]  px_q, py_q;
  logic [PW-1:0]          prx_q, pry_q;
  logic signed [CW-1:0]   cx_q, cy_q;
  logic [MW-1:0]          zx_mag_q, zy_mag_q;
  logic                   zx_neg_q, zy_neg_q;
  logic [SW-1:0]          sx_q, sy_q, pm_q;
  logic                   p_neg_q;
  logic [ITER_BITS-1:0]   n_q;
  logic                   esc_q;

  logic [2*MW-1:0]        sqx, sqy, xy;
  logic [SW:0]            sum;
  logic                   sum_esc, lim, big;
  logic [ITER_BITS-1:0]   limit;
  logic signed [ZW-1:0]   nx, ny, twop;
  logic [7:0]             n8, g8, b8;

  assign limit   = ITER_BITS'(cfg_i.iter_cap);
  assign sum     = {1'b0, sx_q} + {1'b0, sy_q};
  assign sum_esc = sum[SW];                     // |z|^2 >= 4
  assign lim     = n_q >= limit;

  assign nx   = ZW'($signed({1'b0, sx_q})) - ZW'($signed({1'b0, sy_q})) + ZW'(cx_q);
  assign twop = $signed(ZW'({pm_q, 1'b0}));
  assign ny   = p_neg_q ? (ZW'(cy_q) - twop) : (ZW'(cy_q) + twop);
  // either component at or beyond 2 means certain escape
  assign big  = (nx > TWO_M1) || (nx < NEG_TWO_M1) || (ny > TWO_M1) || (ny < NEG_TWO_M1);

  assign sts_o.done = cmd_i.iter & (sum_esc | lim | big);

  assign sqx = (2*MW)'(zx_mag_q) * (2*MW)'(zx_mag_q);
  assign sqy = (2*MW)'(zy_mag_q) * (2*MW)'(zy_mag_q);
  assign xy  = (2*MW)'(zx_mag_q) * (2*MW)'(zy_mag_q);

  assign n8 = n_q[7:0];
  assign g8 = (n8 << 3) - n8;
  assign b8 = (n8 << 3) + (n8 << 2) + n8;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (cmd_i.scale) begin
      prx_q <= PW'(px_q) * PW'(cfg_i.real_step);
      pry_q <= PW'(py_q) * PW'(cfg_i.imag_step);
    end
    if (cmd_i.orig) begin
      cx_q    <= CW'($signed(cfg_i.real_origin)) + CW'($signed({1'b0, prx_q}));
      cy_q    <= CW'($signed(cfg_i.imag_origin)) + CW'($signed({1'b0, pry_q}));
      sx_q    <= '0;
      sy_q    <= '0;
      pm_q    <= '0;
      p_neg_q <= 1'b0;
      n_q     <= '0;
      esc_q   <= 1'b0;
    end
    if (cmd_i.iter) begin
      esc_q <= sum_esc | (~lim & big);
      if (!sum_esc && !lim) begin
        n_q      <= n_q + ITER_BITS'(1);
        zx_neg_q <= nx[ZW-1];
        zy_neg_q <= ny[ZW-1];
        zx_mag_q <= nx[ZW-1] ? MW'(-nx) : MW'(nx);
        zy_mag_q <= ny[ZW-1] ? MW'(-ny) : MW'(ny);
      end
    end
    if (cmd_i.sqr) begin
      // magnitudes truncate toward zero, sign applied on the next update
      sx_q    <= sqx[2*MW-1:FRAC_BITS];
      sy_q    <= sqy[2*MW-1:FRAC_BITS];
      pm_q    <= xy[2*MW-1:FRAC_BITS];
      p_neg_q <= zx_neg_q ^ zy_neg_q;
    end
    if (cmd_i.emit) begin
      out_x_o      <= px_q;
      out_y_o      <= py_q;
      iterations_o <= n_q;
      escaped_o    <= esc_q;
      color_o      <= {n8, g8, b8};
    end
  end

endmodule

FILE: design/mbrot_ctrl.sv
// Controller: sequences mapping, iteration loop and result hand-off.
module mbrot_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbrot_pkg::dp_cmd_t  cmd_o,
  input  mbrot_pkg::dp_sts_t  sts_i
);
  import mbrot_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_ORIG  = 3'd2;
  localparam logic [2:0] S_ITER  = 3'd3;
  localparam logic [2:0] S_SQR   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_ORIG;
      end
      S_ORIG: begin
        cmd_o.orig = 1'b1;
        state_d    = S_ITER;
      end
      S_ITER: begin
        cmd_o.iter = 1'b1;
        state_d    = sts_i.done ? S_DONE : S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = S_ITER;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.emit | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SCALE))
    else $error("accepted request did not start mapping");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_loop_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER && sts_i.done) |=> (state_q == S_DONE))
    else $error("loop finish not followed by done");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule

FILE: design/mandelbrot_escape_time_pixel.sv
// Sequence: load, scale, add origin, then iterations until the limit, |z|^2 >= 4 or a
// component passing 2; one iteration = check/update + squaring; emit waits for a free slot.
// One request in flight; the next request is taken while the finished result waits
// in the output register.
// Reset: rst_ni (async, active low) returns to idle, drops out_valid_o and reloads
// the configuration registers with their default values.
module mandelbrot_escape_time_pixel #(
  parameter int COORD_BITS = mbrot_pkg::DEF_COORD_BITS,
  parameter int ITER_BITS  = mbrot_pkg::DEF_ITER_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbrot_pkg::PADDR_W-1:0] paddr,
  input  logic [mbrot_pkg::PDATA_W-1:0] pwdata,
  output logic [mbrot_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COORD_BITS-1:0]         pixel_x_i,
  input  logic [COORD_BITS-1:0]         pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_BITS-1:0]         out_x_o,
  output logic [COORD_BITS-1:0]         out_y_o,
  output logic [ITER_BITS-1:0]          iterations_o,
  output logic                          escaped_o,
  output logic [23:0]                   color_o
);
  import mbrot_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  mbrot_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbrot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  mbrot_dp #(
    .COORD_BITS (COORD_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .iterations_o (iterations_o),
    .escaped_o    (escaped_o),
    .color_o      (color_o)
  );

endmodule
